FILE: src/cfvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfvp_pkg
// shared widths, types and helpers for the friction velocity projection
// ----------------------------------------------------------------------------
package cfvp_pkg;

    localparam int VEL_W   = 32;
    localparam int NRM_W   = 16;
    localparam int MU_W    = 16;
    localparam int PROD_W  = 48;
    localparam int DOT_W   = 50;
    localparam int AD_W    = 48;
    localparam int PP_W    = 64;
    localparam int P_W     = 34;
    localparam int VT_W    = 36;
    localparam int MAG_W   = 34;
    localparam int SH_W    = 31;
    localparam int SQ_W    = 62;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 34;
    localparam int SQ_N    = 32;
    localparam int LEN_W   = 35;
    localparam int VT24_W  = 43;
    localparam int FRIC_W  = 51;
    localparam int DV_N    = 20;
    localparam int Q_W     = DV_N + 1;
    localparam int FRAC_K  = 20;
    localparam int KP_W    = MAG_W + Q_W;
    localparam int M_W     = KP_W - FRAC_K;
    localparam int SFT_W   = 2;
    localparam int CASE_W  = 2;

    typedef enum logic [CASE_W-1:0] {
        CC_SEPARATE = 2'd0,
        CC_STICK    = 2'd1,
        CC_SLIDE    = 2'd2
    } t_case;

    typedef struct packed {
        logic                        sep;
        logic                        stick;
        logic [2:0][VEL_W-1:0]       vel;
        logic [2:0]                  vt_neg;
        logic [2:0][MAG_W-1:0]       vt_mag;
        logic [1:0][SFT_W-1:0]       sft;
    } t_side;

    // signed saturation of a sign and magnitude to 32 bits
    function automatic logic [VEL_W-1:0] f_sat(input logic neg, input logic [M_W-1:0] m);
        logic [VEL_W-1:0] res;
        if (!neg) begin
            if (m[M_W-1:VEL_W-1] != '0) begin
                res = {1'b0, {(VEL_W-1){1'b1}}};
            end else begin
                res = m[VEL_W-1:0];
            end
        end else begin
            if ((m[M_W-1:VEL_W] != '0) || (m[VEL_W-1] && (m[VEL_W-2:0] != '0))) begin
                res = {1'b1, {(VEL_W-1){1'b0}}};
            end else begin
                res = (~m[VEL_W-1:0]) + 1'b1;
            end
        end
        return res;
    endfunction

endpackage

FILE: src/coulomb_friction_velocity_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coulomb_friction_velocity_projection
// coulomb friction projection of a grid-node velocity against a surface normal
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while the output
// register is free or its result is taken. The pipeline is built from two
// chains of cells: 32 square-root cells (one root bit each, both speeds side
// by side) and 20 divider cells (one scale bit each), plus 12 arithmetic and
// output stages. A stall on the output side holds the whole pipeline; the
// output register lets a new transaction in whenever the held result is taken.
// The friction coefficient mu is written through i_cfg_we / i_cfg_wdata and
// resets to zero.
module coulomb_friction_velocity_projection
    import cfvp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [MU_W-1:0]       i_cfg_wdata,      // friction coefficient mu
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // vel_x, vel_y, vel_z, normal_x, normal_y, normal_z
    input  logic [3*VEL_W+3*NRM_W-1:0] i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [3*VEL_W-1:0]    o_m_axis_tdata,   // out_x, out_y, out_z
    output logic [CASE_W-1:0]     o_m_axis_tuser    // contact_case
);

    function automatic logic [SFT_W-1:0] f_shift(input logic [MAG_W-1:0] a);
        logic [SFT_W-1:0] s;
        if (a[MAG_W-1]) begin
            s = 2'd3;
        end else if (a[MAG_W-2]) begin
            s = 2'd2;
        end else if (a[MAG_W-3]) begin
            s = 2'd1;
        end else begin
            s = 2'd0;
        end
        return s;
    endfunction

    logic                     w_en;
    logic [MU_W-1:0]          r_mu;

    logic [6:0]               r_vld_a;
    logic [SQ_N-1:0]          r_sq_vld;
    logic [2:0]               r_vld_b;
    logic [DV_N-1:0]          r_dv_vld;
    logic                     r_vld11;
    logic                     r_out_vld;

    logic [VEL_W-1:0]         w_in_v [3];
    logic [NRM_W-1:0]         w_in_n [3];
    logic [PROD_W-1:0]        w_ev [3];
    logic [PROD_W-1:0]        w_en3 [3];

    logic [PROD_W-1:0]        r1_prod [3];
    logic [VEL_W-1:0]         r1_v [3];
    logic [NRM_W-1:0]         r1_n [3];

    logic [DOT_W-1:0]         r2_d;
    logic [VEL_W-1:0]         r2_v [3];
    logic [NRM_W-1:0]         r2_n [3];

    logic [DOT_W-1:0]         w_dneg;
    logic [AD_W-1:0]          w_ad;
    logic [NRM_W-1:0]         w_nmag [3];
    logic [PP_W-1:0]          w_pp [3];

    logic                     r3_sep;
    logic [P_W-1:0]           r3_p [3];
    logic                     r3_npos [3];
    logic [VEL_W-1:0]         r3_v [3];

    logic [VT_W-1:0]          w_vt [3];
    logic [VT_W-1:0]          w_vtneg [3];
    t_side                    w_side4;
    t_side                    r4_side;
    logic [MAG_W-1:0]         r4_vnm [3];

    logic [MAG_W-1:0]         w_or [2];
    logic [SFT_W-1:0]         w_sft [2];
    logic [MAG_W-1:0]         w_shm [2][3];
    t_side                    w_side5;
    t_side                    r5_side;
    logic [SH_W-1:0]          r5_sh [2][3];

    t_side                    r6_side;
    logic [SQ_W-1:0]          r6_sq [2][3];

    t_side                    r7_side;
    logic [RAD_W-1:0]         r7_sum [2];

    logic [REM_W-1:0]         w_sq_rem  [2][SQ_N+1];
    logic [ROOT_W-1:0]        w_sq_root [2][SQ_N+1];
    logic [RAD_W-1:0]         w_sq_rad  [2][SQ_N+1];
    t_side                    r_sq_side [SQ_N];

    logic [LEN_W-1:0]         w_len [2];
    t_side                    r8_side;
    logic [FRIC_W-1:0]        r8_fric;
    logic [VT24_W-1:0]        r8_vt24;

    t_side                    w_side9;
    t_side                    r9_side;
    logic [VT24_W-1:0]        r9_num;
    logic [VT24_W-1:0]        r9_den;

    logic                     w_q0;
    t_side                    r10_side;
    logic [VT24_W-1:0]        r10_rem;
    logic [VT24_W-1:0]        r10_den;
    logic                     r10_q0;

    logic [VT24_W-1:0]        w_dv_rem [DV_N+1];
    logic [VT24_W-1:0]        w_dv_den [DV_N+1];
    logic [Q_W-1:0]           w_dv_q   [DV_N+1];
    t_side                    r_dv_side [DV_N];

    t_side                    r11_side;
    logic [KP_W-1:0]          r11_prod [3];

    t_case                    w_case;
    logic [3*VEL_W-1:0]       w_odata;
    logic [3*VEL_W-1:0]       r_out_data;
    t_case                    r_out_case;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // friction coefficient register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu <= '0;
        end else if (i_cfg_we) begin
            r_mu <= i_cfg_wdata;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a   <= '0;
            r_sq_vld  <= '0;
            r_vld_b   <= '0;
            r_dv_vld  <= '0;
            r_vld11   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld_a   <= {r_vld_a[5:0], i_s_axis_tvalid};
            r_sq_vld  <= {r_sq_vld[SQ_N-2:0], r_vld_a[6]};
            r_vld_b   <= {r_vld_b[1:0], r_sq_vld[SQ_N-1]};
            r_dv_vld  <= {r_dv_vld[DV_N-2:0], r_vld_b[2]};
            r_vld11   <= r_dv_vld[DV_N-1];
            r_out_vld <= r_vld11;
        end
    end

    // stages 1 to 7: dot product, normal and tangential parts, squares
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_in_v[i] = i_s_axis_tdata[i*VEL_W +: VEL_W];
            w_in_n[i] = i_s_axis_tdata[3*VEL_W + i*NRM_W +: NRM_W];
            w_ev[i]   = {{(PROD_W-VEL_W){w_in_v[i][VEL_W-1]}}, w_in_v[i]};
            w_en3[i]  = {{(PROD_W-NRM_W){w_in_n[i][NRM_W-1]}}, w_in_n[i]};
        end
        w_dneg = (~r2_d) + 1'b1;
        w_ad   = r2_d[DOT_W-1] ? w_dneg[AD_W-1:0] : r2_d[AD_W-1:0];
        for (int i = 0; i < 3; i++) begin
            w_nmag[i] = r2_n[i][NRM_W-1] ? ((~r2_n[i]) + 1'b1) : r2_n[i];
            w_pp[i]   = PP_W'(w_ad) * PP_W'(w_nmag[i]);
        end
        w_side4        = '0;
        w_side4.sep    = r3_sep;
        for (int i = 0; i < 3; i++) begin
            if (r3_npos[i]) begin
                w_vt[i] = {{(VT_W-VEL_W){r3_v[i][VEL_W-1]}}, r3_v[i]}
                          + {{(VT_W-P_W){1'b0}}, r3_p[i]};
            end else begin
                w_vt[i] = {{(VT_W-VEL_W){r3_v[i][VEL_W-1]}}, r3_v[i]}
                          - {{(VT_W-P_W){1'b0}}, r3_p[i]};
            end
            w_vtneg[i]        = (~w_vt[i]) + 1'b1;
            w_side4.vel[i]    = r3_v[i];
            w_side4.vt_neg[i] = w_vt[i][VT_W-1];
            w_side4.vt_mag[i] = w_vt[i][VT_W-1] ? w_vtneg[i][MAG_W-1:0] : w_vt[i][MAG_W-1:0];
        end
        w_or[0] = r4_vnm[0] | r4_vnm[1] | r4_vnm[2];
        w_or[1] = r4_side.vt_mag[0] | r4_side.vt_mag[1] | r4_side.vt_mag[2];
        w_side5 = r4_side;
        for (int k = 0; k < 2; k++) begin
            w_sft[k]        = f_shift(w_or[k]);
            w_side5.sft[k]  = w_sft[k];
        end
        for (int i = 0; i < 3; i++) begin
            w_shm[0][i] = r4_vnm[i] >> w_sft[0];
            w_shm[1][i] = r4_side.vt_mag[i] >> w_sft[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_prod[i] <= w_ev[i] * w_en3[i];
                r1_v[i]    <= w_in_v[i];
                r1_n[i]    <= w_in_n[i];
                r2_v[i]    <= r1_v[i];
                r2_n[i]    <= r1_n[i];
                r3_p[i]    <= w_pp[i][PP_W-1 -: P_W];
                r3_npos[i] <= !r2_n[i][NRM_W-1] && (r2_n[i] != '0);
                r3_v[i]    <= r2_v[i];
                r4_vnm[i]  <= r3_p[i];
            end
            r2_d    <= {{(DOT_W-PROD_W){r1_prod[0][PROD_W-1]}}, r1_prod[0]}
                     + {{(DOT_W-PROD_W){r1_prod[1][PROD_W-1]}}, r1_prod[1]}
                     + {{(DOT_W-PROD_W){r1_prod[2][PROD_W-1]}}, r1_prod[2]};
            r3_sep  <= !r2_d[DOT_W-1] && (r2_d != '0);
            r4_side <= w_side4;
            r5_side <= w_side5;
            r6_side <= r5_side;
            r7_side <= r6_side;
            for (int k = 0; k < 2; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r5_sh[k][i] <= w_shm[k][i][SH_W-1:0];
                    r6_sq[k][i] <= SQ_W'(r5_sh[k][i]) * SQ_W'(r5_sh[k][i]);
                end
                r7_sum[k] <= RAD_W'(r6_sq[k][0]) + RAD_W'(r6_sq[k][1]) + RAD_W'(r6_sq[k][2]);
            end
        end
    end

    // square-root cell chains: index 0 normal speed, index 1 tangential speed
    genvar gk, gj;
    generate
        for (gk = 0; gk < 2; gk++) begin : g_sq_row
            assign w_sq_rem[gk][0]  = '0;
            assign w_sq_root[gk][0] = '0;
            assign w_sq_rad[gk][0]  = r7_sum[gk];
            for (gj = 0; gj < SQ_N; gj++) begin : g_sq_cell
                cfvp_sqrt_cell u_cell (
                    .i_clk  (i_clk),
                    .i_en   (w_en),
                    .i_rem  (w_sq_rem[gk][gj]),
                    .i_root (w_sq_root[gk][gj]),
                    .i_rad  (w_sq_rad[gk][gj]),
                    .o_rem  (w_sq_rem[gk][gj+1]),
                    .o_root (w_sq_root[gk][gj+1]),
                    .o_rad  (w_sq_rad[gk][gj+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0] <= r7_side;
            for (int j = 1; j < SQ_N; j++) begin
                r_sq_side[j] <= r_sq_side[j-1];
            end
        end
    end

    // stages 8 to 10: friction bound, stick test, first quotient bit
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_len[k] = LEN_W'(w_sq_root[k][SQ_N]) << r_sq_side[SQ_N-1].sft[k];
        end
        w_side9       = r8_side;
        w_side9.stick = ({{(FRIC_W-VT24_W){1'b0}}, r8_vt24} <= r8_fric);
        w_q0          = (r9_num >= r9_den);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_side  <= r_sq_side[SQ_N-1];
            r8_fric  <= FRIC_W'(r_mu) * FRIC_W'(w_len[0]);
            r8_vt24  <= {w_len[1], 8'b0};
            r9_side  <= w_side9;
            r9_num   <= r8_vt24 - r8_fric[VT24_W-1:0];
            r9_den   <= r8_vt24;
            r10_side <= r9_side;
            r10_den  <= r9_den;
            r10_q0   <= w_q0;
            r10_rem  <= w_q0 ? (r9_num - r9_den) : r9_num;
        end
    end

    // divider cell chain for the sliding scale
    assign w_dv_rem[0] = r10_rem;
    assign w_dv_den[0] = r10_den;
    assign w_dv_q[0]   = {{(Q_W-1){1'b0}}, r10_q0};

    generate
        for (gj = 0; gj < DV_N; gj++) begin : g_dv_cell
            cfvp_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_rem (w_dv_rem[gj]),
                .i_den (w_dv_den[gj]),
                .i_q   (w_dv_q[gj]),
                .o_rem (w_dv_rem[gj+1]),
                .o_den (w_dv_den[gj+1]),
                .o_q   (w_dv_q[gj+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_side[0] <= r10_side;
            for (int j = 1; j < DV_N; j++) begin
                r_dv_side[j] <= r_dv_side[j-1];
            end
        end
    end

    // stage 11 and output register
    always_comb begin
        if (r11_side.sep) begin
            w_case  = CC_SEPARATE;
            w_odata = r11_side.vel;
        end else if (r11_side.stick) begin
            w_case  = CC_STICK;
            w_odata = '0;
        end else begin
            w_case  = CC_SLIDE;
            for (int i = 0; i < 3; i++) begin
                w_odata[i*VEL_W +: VEL_W] = f_sat(r11_side.vt_neg[i],
                                                  r11_prod[i][KP_W-1:FRAC_K]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_side <= r_dv_side[DV_N-1];
            for (int i = 0; i < 3; i++) begin
                r11_prod[i] <= KP_W'(r_dv_side[DV_N-1].vt_mag[i]) * KP_W'(w_dv_q[DV_N]);
            end
            r_out_data <= w_odata;
            r_out_case <= w_case;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_case;

endmodule

FILE: src/cfvp_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfvp_sqrt_cell
// one digit step of a restoring integer square root, registered
// ----------------------------------------------------------------------------
module cfvp_sqrt_cell
    import cfvp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [REM_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root,
    output logic [RAD_W-1:0]  o_rad
);

    logic [REM_W+1:0]  w_acc;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_ge;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;
    logic [RAD_W-1:0]  n_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [RAD_W-1:0]  r_rad;

    always_comb begin
        w_acc   = {i_rem, i_rad[RAD_W-1 -: 2]};
        w_trial = {{(REM_W-ROOT_W){1'b0}}, i_root, 2'b01};
        w_diff  = w_acc - w_trial;
        w_ge    = (w_acc >= w_trial);
        n_rem   = w_ge ? w_diff[REM_W-1:0] : w_acc[REM_W-1:0];
        n_root  = {i_root[ROOT_W-2:0], w_ge};
        n_rad   = {i_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

FILE: src/cfvp_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfvp_div_cell
// one quotient bit of a restoring fraction divider, registered
// ----------------------------------------------------------------------------
module cfvp_div_cell
    import cfvp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [VT24_W-1:0] i_rem,
    input  logic [VT24_W-1:0] i_den,
    input  logic [Q_W-1:0]    i_q,
    output logic [VT24_W-1:0] o_rem,
    output logic [VT24_W-1:0] o_den,
    output logic [Q_W-1:0]    o_q
);

    logic [VT24_W:0]   w_acc;
    logic [VT24_W:0]   w_diff;
    logic              w_ge;
    logic [VT24_W-1:0] n_rem;
    logic [Q_W-1:0]    n_q;
    logic [VT24_W-1:0] r_rem;
    logic [VT24_W-1:0] r_den;
    logic [Q_W-1:0]    r_q;

    always_comb begin
        w_acc  = {i_rem, 1'b0};
        w_diff = w_acc - {1'b0, i_den};
        w_ge   = (w_acc >= {1'b0, i_den});
        n_rem  = w_ge ? w_diff[VT24_W-1:0] : w_acc[VT24_W-1:0];
        n_q    = {i_q[Q_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;

endmodule

FILE: bench/tb_coulomb_friction_velocity_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coulomb_friction_velocity_projection
// self-checking bench: directed and random velocity/normal transactions are
// streamed with random gaps on both sides, a behavioral friction projection
// predicts each result and a scoreboard compares them in order
// ----------------------------------------------------------------------------
module tb_coulomb_friction_velocity_projection;
    import cfvp_pkg::*;

    typedef struct {
        logic [31:0] ox, oy, oz;
        t_case       cc;
    } t_vel_result;

    class friction_scoreboard;
        t_vel_result pending[$];
        int          errors;
        logic [15:0] mu;

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned speed(longint unsigned a, longint unsigned b,
                                        longint unsigned c);
            int s;
            longint unsigned sa, sb, sc;
            s = 0;
            while (((a | b | c) >> s) >= (64'd1 << 31)) s++;
            sa = a >> s;
            sb = b >> s;
            sc = c >> s;
            return isqrt(sa * sa + sb * sb + sc * sc) << s;
        endfunction

        function longint unsigned absv(longint x);
            return x < 0 ? -x : x;
        endfunction

        function logic [31:0] clip32(longint x);
            if (x > 64'sd2147483647) x = 64'sd2147483647;
            if (x < -64'sd2147483648) x = -64'sd2147483648;
            return x[31:0];
        endfunction

        function void note_input(logic [32*3+16*3-1:0] td);
            longint v[3], n[3], vn[3], vt[3];
            longint d, mm;
            longint unsigned ad, p, vnn, vtn, fric, vt24, k;
            t_vel_result r;
            d = 0;
            for (int i = 0; i < 3; i++) begin
                v[i] = $signed(td[32*i +: 32]);
                n[i] = $signed(td[96 + 16*i +: 16]);
                d += v[i] * n[i];
            end
            if (d > 0) begin
                r.ox = td[31:0];
                r.oy = td[63:32];
                r.oz = td[95:64];
                r.cc = CC_SEPARATE;
            end else begin
                ad = absv(d);
                for (int i = 0; i < 3; i++) begin
                    p = (ad * absv(n[i])) >> 30;
                    vn[i] = n[i] > 0 ? -longint'(p) : longint'(p);
                    vt[i] = v[i] - vn[i];
                end
                vnn = speed(absv(vn[0]), absv(vn[1]), absv(vn[2]));
                vtn = speed(absv(vt[0]), absv(vt[1]), absv(vt[2]));
                fric = mu * vnn;
                vt24 = vtn << 8;
                if (vt24 <= fric) begin
                    r.ox = 0;
                    r.oy = 0;
                    r.oz = 0;
                    r.cc = CC_STICK;
                end else begin
                    k = ((vt24 - fric) << 20) / vt24;
                    mm = (absv(vt[0]) * k) >> 20;
                    r.ox = clip32(vt[0] < 0 ? -mm : mm);
                    mm = (absv(vt[1]) * k) >> 20;
                    r.oy = clip32(vt[1] < 0 ? -mm : mm);
                    mm = (absv(vt[2]) * k) >> 20;
                    r.oz = clip32(vt[2] < 0 ? -mm : mm);
                    r.cc = CC_SLIDE;
                end
            end
            pending.push_back(r);
        endfunction

        task check_result(logic [95:0] td, logic [1:0] tu);
            t_vel_result e;
            if (pending.size() == 0) begin
                report("result with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (td[31:0] !== e.ox) report("out_x mismatch");
            if (td[63:32] !== e.oy) report("out_y mismatch");
            if (td[95:64] !== e.oz) report("out_z mismatch");
            if (tu !== e.cc) report("contact_case mismatch");
        endtask

        task report(string msg);
            $display("mismatch: %s at %0t", msg, $time);
            errors++;
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0, i_cfg_we = 0;
    logic [15:0] i_cfg_wdata = 0;
    logic i_s_axis_tvalid = 0, i_m_axis_tready = 0;
    logic [32*3+16*3-1:0] i_s_axis_tdata = 0;
    logic o_s_axis_tready, o_m_axis_tvalid;
    logic [95:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;
    friction_scoreboard sb;
    int idle_cycles = 0;
    bit sink_hold = 0;

    always #5 i_clk = ~i_clk;

    coulomb_friction_velocity_projection dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("[coulomb_friction_velocity_projection] ERROR");
            $finish;
        end
    end

    // sink: random stalls between results
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            w = (sink_hold || $urandom_range(3) == 0) ? 0 : $urandom_range(5);
            i_m_axis_tready <= (w == 0);
            @(posedge i_clk);
            if (w != 0) begin
                repeat (w - 1) @(posedge i_clk);
                i_m_axis_tready <= 1;
                @(posedge i_clk);
            end
            while (!(o_m_axis_tvalid && i_m_axis_tready)) @(posedge i_clk);
        end
    end

    task automatic send_item(logic [32*3+16*3-1:0] td, bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(5);
        if (w != 0) begin
            i_s_axis_tvalid <= 0;
            repeat (w) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata <= td;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_input(td);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_mu(logic [15:0] m);
        i_cfg_we <= 1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.mu = m;
    endtask

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(4))
            0: return $urandom;
            1: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    function automatic logic [15:0] rand_nrm();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            2: return 16'd0;
            default: return {{3{$urandom_range(1) == 1}}, 13'($urandom)};
        endcase
    endfunction

    function automatic logic [32*3+16*3-1:0] pack_item(logic [31:0] x, logic [31:0] y,
            logic [31:0] z, logic [15:0] a, logic [15:0] b, logic [15:0] c);
        return {c, b, a, z, y, x};
    endfunction

    initial begin
        logic [15:0] mus [5];
        sb = new();
        sb.mu = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: mu zero after reset
        send_item(pack_item(0, 0, 0, 0, 0, 0), 0);
        send_item(pack_item(32'h10000, 0, 0, 16'h7fff, 0, 0), 0);
        send_item(pack_item(32'hffff0000, 0, 0, 16'h7fff, 0, 0), 0);
        send_item(pack_item(32'h10000, 32'h10000, 0, 0, 0, 0), 0);
        drain();
        write_mu(16'h0100);
        send_item(pack_item(32'hffff0000, 32'h8000, 0, 16'h7fff, 0, 0), 0);
        send_item(pack_item(32'hffff0000, 32'h30000, 0, 16'h7fff, 0, 0), 0);
        send_item(pack_item(0, 32'h10000, 0, 16'h7fff, 0, 0), 0);
        send_item(pack_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            16'h8000, 16'h8000, 16'h8000), 0);
        send_item(pack_item(32'h80000000, 32'h80000000, 32'h80000000,
                            16'h7fff, 16'h7fff, 16'h7fff), 0);
        send_item(pack_item(32'h80000000, 32'h7fffffff, 32'h80000000,
                            16'h8000, 16'h7fff, 16'h8000), 0);
        send_item(pack_item(32'h80000000, 0, 0, 16'h8000, 0, 0), 0);
        send_item(pack_item(32'h7fffffff, 0, 0, 16'h7fff, 0, 0), 0);
        send_item(pack_item(0, 0, 0, 16'h7fff, 16'h7fff, 0), 0);
        drain();
        write_mu(16'hffff);
        send_item(pack_item(32'hffff0000, 32'h10000, 32'h10000, 16'h7fff, 0, 0), 0);
        send_item(pack_item(32'h80000000, 32'h7fffffff, 0, 16'h4000, 0, 0), 0);
        mus = '{16'h0000, 16'h0040, 16'h0100, 16'h0380, 16'hffff};
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_mu(ph == 4 ? 16'($urandom) : mus[ph]);
            for (int i = 0; i < 216; i++) begin
                if (ph == 2 && i == 100) begin
                    // hold the source until everything has drained
                    i_s_axis_tvalid <= 0;
                    @(posedge i_clk);
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
                sink_hold = (i % 100) < 15;
                send_item(pack_item(rand_vel(), rand_vel(), rand_vel(),
                                    rand_nrm(), rand_nrm(), rand_nrm()),
                          sink_hold || $urandom_range(3) == 0);
            end
        end
        sink_hold = 0;
        drain();
        if (sb.errors == 0)
            $display("[coulomb_friction_velocity_projection] OK");
        else
            $display("[coulomb_friction_velocity_projection] ERROR");
        $finish;
    end
endmodule

FILE: sim.f
src/cfvp_pkg.sv
src/cfvp_sqrt_cell.sv
src/cfvp_div_cell.sv
src/coulomb_friction_velocity_projection.sv
bench/tb_coulomb_friction_velocity_projection.sv
